FILE: hdl/rdft_pkg.sv
// Shared constants, types and twiddle generation for the real forward DFT block.
`default_nettype none

package rdft_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int TWIDDLE_BITS_DEF = 16;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 23;
  localparam int BIN_W    = 6;
  localparam int CFG_W    = 3;
  localparam int COUNT_W  = 7;

  localparam logic [CFG_W-1:0] LG_MIN   = 3'd2;
  localparam logic [CFG_W-1:0] LG_MAX   = 3'd6;
  localparam logic [CFG_W-1:0] LG_RESET = 3'd6;

  localparam int STORE_CAP = 1 << LG_MAX;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // (2i)(2i+1) for Taylor terms i = 1 .. 12
  localparam longint unsigned TAYLOR_DIV [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  // sin(x) for x in Q30, scaled to tw bits, saturated at the positive limit
  function automatic longint quarter_sine(input longint unsigned x, input int tw);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          top;
    longint          v;
    int              sh;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    sh   = 31 - tw;
    top  = (longint'(1) << (tw - 1)) - 1;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[i-1];
      if ((i % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = longint'((longint'(unsigned'(sum)) + (longint'(1) << (sh - 1))) >> sh);
    if (v > top) begin
      v = top;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rdft_sample_store.sv
// Sample memory: one write port, one registered read port.
`default_nettype none

module rdft_sample_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [AW-1:0]                        waddr_i,
  input  wire logic signed [rdft_pkg::SAMPLE_W-1:0] wdata_i,
  input  wire logic [AW-1:0]                        raddr_i,
  output logic signed [rdft_pkg::SAMPLE_W-1:0]      rdata_o
);
  import rdft_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/rdft_twiddle.sv
// Quarter-wave twiddle table with quadrant folding, registered cosine and sine.
`default_nettype none

module rdft_twiddle #(
  parameter int MAX_POINTS   = rdft_pkg::MAX_POINTS_DEF,
  parameter int TWIDDLE_BITS = rdft_pkg::TWIDDLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0]   phase_i,
  output logic signed [TWIDDLE_BITS-1:0]       cos_o,
  output logic signed [TWIDDLE_BITS-1:0]       sin_o
);
  import rdft_pkg::*;

  localparam int PH_W = $clog2(MAX_POINTS);
  localparam int QTR  = MAX_POINTS / 4;
  localparam int RA   = $clog2(QTR + 1);
  localparam logic [PH_W-1:0] QtrPh  = PH_W'(QTR);
  localparam logic [PH_W-1:0] QtrMsk = PH_W'(QTR - 1);

  logic signed [TWIDDLE_BITS-1:0] rom [QTR+1];

  for (genvar m = 0; m <= QTR; m++) begin : g_rom
    localparam longint unsigned XQ = (HALF_PI_Q30 * longint'(m)) / QTR;
    localparam logic signed [TWIDDLE_BITS-1:0] TwVal =
      TWIDDLE_BITS'(quarter_sine(XQ, TWIDDLE_BITS));
    assign rom[m] = TwVal;
  end

  logic [PH_W-1:0] ph_s, ph_c, r_s, r_c, idx_s, idx_c;
  logic signed [TWIDDLE_BITS-1:0] v_s, v_c;

  always_comb begin
    ph_s  = phase_i;
    ph_c  = phase_i + QtrPh;
    r_s   = ph_s & QtrMsk;
    r_c   = ph_c & QtrMsk;
    idx_s = ph_s[PH_W-2] ? (QtrPh - r_s) : r_s;
    idx_c = ph_c[PH_W-2] ? (QtrPh - r_c) : r_c;
    v_s   = rom[idx_s[RA-1:0]];
    v_c   = rom[idx_c[RA-1:0]];
  end

  always_ff @(posedge clk_i) begin
    sin_o <= ph_s[PH_W-1] ? -v_s : v_s;
    cos_o <= ph_c[PH_W-1] ? -v_c : v_c;
  end

endmodule

`default_nettype wire

FILE: hdl/rdft_mac.sv
// Multiply-accumulate pair with rounding back to the input scale.
`default_nettype none

module rdft_mac #(
  parameter int TWIDDLE_BITS = rdft_pkg::TWIDDLE_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire rdft_pkg::mac_ctrl_t                  ctrl_i,
  input  wire logic signed [rdft_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic signed [TWIDDLE_BITS-1:0]       cos_i,
  input  wire logic signed [TWIDDLE_BITS-1:0]       sin_i,
  output logic                                      done_o,
  output logic signed [rdft_pkg::OUT_W-1:0]         real_o,
  output logic signed [rdft_pkg::OUT_W-1:0]         imag_o
);
  import rdft_pkg::*;

  localparam int PROD_W = SAMPLE_W + TWIDDLE_BITS;
  localparam int ACC_W  = TWIDDLE_BITS + 22;
  localparam logic signed [ACC_W-1:0] RndBias = ACC_W'(1) <<< (TWIDDLE_BITS - 2);

  mac_ctrl_t                 ctrl_a_q;
  logic signed [PROD_W-1:0]  prod_re_q, prod_im_q;
  logic signed [ACC_W-1:0]   acc_re_q, acc_im_q;
  logic signed [ACC_W-1:0]   re_bias, im_bias;
  logic                      done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
      done_q   <= 1'b0;
    end else begin
      ctrl_a_q <= ctrl_i;
      done_q   <= ctrl_a_q.valid && ctrl_a_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_re_q <= sample_i * cos_i;
    prod_im_q <= sample_i * sin_i;
    if (ctrl_a_q.valid) begin
      if (ctrl_a_q.first) begin
        acc_re_q <= ACC_W'(prod_re_q);
        acc_im_q <= ACC_W'(prod_im_q);
      end else begin
        acc_re_q <= acc_re_q + ACC_W'(prod_re_q);
        acc_im_q <= acc_im_q + ACC_W'(prod_im_q);
      end
    end
  end

  always_comb begin
    re_bias = acc_re_q + RndBias;
    im_bias = acc_im_q + RndBias;
  end

  assign real_o = OUT_W'(re_bias >>> (TWIDDLE_BITS - 1));
  assign imag_o = OUT_W'(im_bias >>> (TWIDDLE_BITS - 1));
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: hdl/real_dft_forward_top.sv
// Top level of the real forward DFT: sequencer, configuration and output register.
//
//  channel  | signals                      | direction | contents
//  ---------+------------------------------+-----------+------------------------------
//  samples  | s_axis_tvalid/tready/tdata   | in        | sample
//  bins     | m_axis_tvalid/tready/tdata   | out       | real, imag, bin; tlast=last
//  config   | cfg_we_i, cfg_wdata_i        | in        | log2_points
//
// Loading accepts one sample per cycle.
// After the final sample each bin is computed in the shared multiply-accumulate pair
// (N products through the read, product and accumulate registers, then the output register load).
// The input is not ready while bins are computed; a stalled output holds the next bin.
// Reset clears the sequencer, the load count and sets the length register to 64 points.
`default_nettype none

module real_dft_forward_top #(
  parameter int MAX_POINTS   = rdft_pkg::MAX_POINTS_DEF,
  parameter int TWIDDLE_BITS = rdft_pkg::TWIDDLE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rdft_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [15:0]                    s_axis_tdata,  // [15:0] sample
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [55:0]                         m_axis_tdata,  // [22:0] real_part,
                                                             // [45:23] imag_part,
                                                             // [51:46] bin_index
  output logic                                m_axis_tlast   // last_bin
);
  import rdft_pkg::*;

  localparam int LOG2_MAX = $clog2(MAX_POINTS);
  localparam int PH_W     = LOG2_MAX;
  localparam int ST_DEPTH = (MAX_POINTS < STORE_CAP) ? MAX_POINTS : STORE_CAP;
  localparam int ST_AW    = $clog2(ST_DEPTH);
  localparam logic [CFG_W-1:0] LgCap = (LOG2_MAX < int'(LG_MAX)) ? CFG_W'(LOG2_MAX) : LG_MAX;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CFG_W-1:0]   log2_points_q;
  logic [COUNT_W-1:0] load_count_q, load_count_d, lc_next;
  logic [BIN_W-1:0]   k_q, k_d, n_q, n_d;
  logic [PH_W-1:0]    phase_q, phase_d, step_q, step_d, stride;
  logic [CFG_W-1:0]   lg;
  logic [COUNT_W-1:0] n_pts;
  logic               in_fire, out_free, n_last, k_last, out_load;
  mac_ctrl_t          issue, ctrl_s1_q;

  logic signed [SAMPLE_W-1:0]     smp_rd;
  logic signed [TWIDDLE_BITS-1:0] cos_tw, sin_tw;
  logic                           mac_done;
  logic signed [OUT_W-1:0]        mac_re, mac_im;

  logic                    m_valid_q;
  logic signed [OUT_W-1:0] real_q, imag_q;
  logic [BIN_W-1:0]        bin_q;
  logic                    last_q;

  always_comb begin
    lg = log2_points_q;
    if (lg < LG_MIN) begin
      lg = LG_MIN;
    end else if (lg > LG_MAX) begin
      lg = LG_MAX;
    end
    if (lg > LgCap) begin
      lg = LgCap;
    end
    n_pts  = COUNT_W'(1) << lg;
    stride = PH_W'(MAX_POINTS >> lg);
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign lc_next       = load_count_q + COUNT_W'(1);
  assign n_last        = (COUNT_W'(n_q) + COUNT_W'(1)) == n_pts;
  assign k_last        = (COUNT_W'(k_q) + COUNT_W'(1)) == n_pts;
  assign out_load      = (state_q == ST_EMIT) && out_free;

  always_comb begin
    issue.valid = (state_q == ST_RUN);
    issue.first = (n_q == '0);
    issue.last  = n_last;
  end

  always_comb begin
    state_d      = state_q;
    load_count_d = load_count_q;
    k_d          = k_q;
    n_d          = n_q;
    phase_d      = phase_q;
    step_d       = step_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (lc_next >= n_pts) begin
            load_count_d = '0;
            k_d          = '0;
            n_d          = '0;
            phase_d      = '0;
            step_d       = '0;
            state_d      = ST_RUN;
          end else begin
            load_count_d = lc_next;
          end
        end
      end
      ST_RUN: begin
        phase_d = phase_q + step_q;
        n_d     = n_q + BIN_W'(1);
        if (n_last) begin
          n_d     = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (k_last) begin
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + BIN_W'(1);
            step_d  = step_q + stride;
            phase_d = '0;
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_LOAD;
      log2_points_q <= LG_RESET;
      load_count_q  <= '0;
      k_q           <= '0;
      n_q           <= '0;
      phase_q       <= '0;
      step_q        <= '0;
      ctrl_s1_q     <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      load_count_q <= load_count_d;
      k_q          <= k_d;
      n_q          <= n_d;
      phase_q      <= phase_d;
      step_q       <= step_d;
      ctrl_s1_q    <= issue;
      if (cfg_we_i) begin
        log2_points_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      real_q <= mac_re;
      imag_q <= mac_im;
      bin_q  <= k_q;
      last_q <= k_last;
    end
  end

  rdft_sample_store #(
    .DEPTH (ST_DEPTH),
    .AW    (ST_AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (load_count_q[ST_AW-1:0]),
    .wdata_i (s_axis_tdata[SAMPLE_W-1:0]),
    .raddr_i (n_q[ST_AW-1:0]),
    .rdata_o (smp_rd)
  );

  rdft_twiddle #(
    .MAX_POINTS   (MAX_POINTS),
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_twiddle (
    .clk_i   (clk_i),
    .phase_i (phase_q),
    .cos_o   (cos_tw),
    .sin_o   (sin_tw)
  );

  rdft_mac #(
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl_s1_q),
    .sample_i (smp_rd),
    .cos_i    (cos_tw),
    .sin_i    (sin_tw),
    .done_o   (mac_done),
    .real_o   (mac_re),
    .imag_o   (mac_im)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, bin_q, imag_q, real_q};
  assign m_axis_tlast  = last_q;

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == ST_DRAIN)
    else $error("accumulator finished outside drain");

  a_last_is_final_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (COUNT_W'(bin_q) + COUNT_W'(1)) == n_pts)
    else $error("last flag on a bin other than the final one");

  a_run_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> COUNT_W'(n_q) < n_pts)
    else $error("sample index beyond transform length");

  a_emit_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("bin not presented after load");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the real forward DFT: directed table, then random blocks, bin by bin.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdft_pkg::*;

  localparam int PTS         = STORE_CAP;
  localparam int QTR         = PTS / 4;
  localparam int RAND_ITEMS  = 137;
  localparam int CALM_AT     = 105;
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = PTS + 8;
  localparam int PLAN_LEN    = 27;

  localparam logic [CFG_W-1:0] LG_OVER = 3'd7;
  localparam logic [CFG_W-1:0] LG_ZERO = 3'd0;
  localparam logic [CFG_W-1:0] LG_ONE  = 3'd1;
  localparam logic [CFG_W-1:0] LG_EIGHT = 3'd3;

  typedef longint unsigned u64_t;

  localparam longint TW_TOP = (longint'(1) << (TWIDDLE_BITS_DEF - 1)) - 1;

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic [BIN_W-1:0]        idx;
    logic                    last;
  } bin_t;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [SAMPLE_W-1:0]     val;
    logic                    typed;
    logic signed [OUT_W-1:0] re0;
    logic signed [OUT_W-1:0] im0;
  } row_t;

  localparam row_t PLAN [PLAN_LEN] = '{
    '{ROW_SMP, 16'h7FFF, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h8000, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h0001, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'hFFFF, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h5555, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'hAAAA, 1'b0, 23'sd0, 23'sd0},
    '{ROW_CFG, 16'(LG_ZERO), 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h1234, 1'b0, 23'sd0, 23'sd0},
    '{ROW_CFG, 16'(LG_MIN), 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h7FFF, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h7FFF, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h7FFF, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h7FFF, 1'b1, 23'sd131064, 23'sd0},
    '{ROW_CFG, 16'(LG_ONE), 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h8000, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h8000, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h8000, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h8000, 1'b1, -23'sd131068, 23'sd0},
    '{ROW_CFG, 16'(LG_EIGHT), 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h0000, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h7FFF, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h8000, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h0000, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h0001, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'hFFFF, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'h4000, 1'b0, 23'sd0, 23'sd0},
    '{ROW_SMP, 16'hC000, 1'b0, 23'sd0, 23'sd0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [55:0]         m_axis_tdata;
  logic                m_axis_tlast;

  longint                     tw_rom [0:QTR];
  logic signed [SAMPLE_W-1:0] held [PTS];
  logic [COUNT_W-1:0]         load_cnt = '0;
  logic [CFG_W-1:0]           len_code = LG_RESET;
  bin_t                       bins_due [$];

  int err_cnt   = 0;
  int smp_cnt   = 0;
  int bin_cnt   = 0;
  int blk_cnt   = 0;
  int len_mask  = 0;
  int code_mask = 0;
  int hold_left = 0;
  int quiet     = 0;
  bit calm      = 1'b0;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;

  real_dft_forward_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint quarter_q15(input int m);
    u64_t   ang;
    u64_t   ang2;
    u64_t   term;
    u64_t   den;
    u64_t   v;
    longint acc;
    int     i;
    ang  = (HALF_PI_Q30 * u64_t'(m)) / u64_t'(QTR);
    ang2 = (ang * ang) >> 30;
    term = ang;
    acc  = longint'(ang);
    for (i = 1; i <= 12; i++) begin
      den  = u64_t'((2 * i) * (2 * i + 1));
      term = ((term * ang2) >> 30) / den;
      if (i % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (u64_t'(acc) + (u64_t'(1) << (30 - TWIDDLE_BITS_DEF))) >> (31 - TWIDDLE_BITS_DEF);
    if (v > u64_t'(TW_TOP)) begin
      v = u64_t'(TW_TOP);
    end
    return longint'(v);
  endfunction

  function automatic longint wave(input int unsigned ph);
    int unsigned q;
    int unsigned r;
    longint      v;
    q = (ph % PTS) / QTR;
    r = ph % QTR;
    v = q[0] ? tw_rom[QTR - r] : tw_rom[r];
    return q[1] ? -v : v;
  endfunction

  function automatic logic signed [OUT_W-1:0] to_out(input longint acc);
    longint r;
    r = (acc + (longint'(1) <<< (TWIDDLE_BITS_DEF - 2))) >>> (TWIDDLE_BITS_DEF - 1);
    return r[OUT_W-1:0];
  endfunction

  function automatic int length_now();
    logic [CFG_W-1:0] c;
    c = len_code;
    if (c < LG_MIN) begin
      c = LG_MIN;
    end
    if (c > LG_MAX) begin
      c = LG_MAX;
    end
    return 1 << c;
  endfunction

  // store one sample; on the closing sample of a block queue all its bins
  function automatic void load_sample(input logic [SAMPLE_W-1:0] v, input logic typed,
                                      input logic signed [OUT_W-1:0] re0,
                                      input logic signed [OUT_W-1:0] im0);
    int     npts;
    int     stride;
    int     ph;
    int     k;
    int     n;
    longint re_acc;
    longint im_acc;
    bin_t   b;
    npts   = length_now();
    stride = PTS / npts;
    held[load_cnt[BIN_W-1:0]] = v;
    load_cnt = load_cnt + 1'b1;
    smp_cnt++;
    if (load_cnt < npts) begin
      return;
    end
    load_cnt = '0;
    blk_cnt++;
    len_mask |= npts;
    for (k = 0; k < npts; k++) begin
      re_acc = 0;
      im_acc = 0;
      for (n = 0; n < npts; n++) begin
        ph = ((k * n) % npts) * stride;
        re_acc += longint'(held[n]) * wave(ph + QTR);
        im_acc += longint'(held[n]) * wave(ph);
      end
      b.re   = to_out(re_acc);
      b.im   = to_out(im_acc);
      if (typed && k == 0) begin
        b.re = re0;
        b.im = im0;
      end
      b.idx  = k[BIN_W-1:0];
      b.last = (k == npts - 1);
      bins_due.push_back(b);
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] v, input logic typed,
                             input logic signed [OUT_W-1:0] re0,
                             input logic signed [OUT_W-1:0] im0);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    load_sample(v, typed, re0, im0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    len_code     = v;
    code_mask   |= 1 << v;
  endtask

  always @(posedge clk_i) begin
    bin_t got;
    bin_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.re   = m_axis_tdata[OUT_W-1:0];
      got.im   = m_axis_tdata[2*OUT_W-1:OUT_W];
      got.idx  = m_axis_tdata[2*OUT_W+BIN_W-1:2*OUT_W];
      got.last = m_axis_tlast;
      if (bins_due.size() == 0) begin
        $error("bin transfer with nothing expected: bin_index %0d", got.idx);
        err_cnt++;
      end else begin
        want = bins_due.pop_front();
        bin_cnt++;
        if (got.re !== want.re) begin
          $error("real_part: expected %0d, got %0d", want.re, got.re);
          err_cnt++;
        end
        if (got.im !== want.im) begin
          $error("imag_part: expected %0d, got %0d", want.im, got.im);
          err_cnt++;
        end
        if (got.idx !== want.idx) begin
          $error("bin_index: expected %0d, got %0d", want.idx, got.idx);
          err_cnt++;
        end
        if (got.last !== want.last) begin
          $error("last_bin: expected %0d, got %0d", want.last, got.last);
          err_cnt++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_left      = $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles", quiet);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int               rand_sent;
    int               phase;
    int               blocks;
    int               npts;
    int               b;
    int               j;
    int               i;
    logic [CFG_W-1:0] code;
    for (i = 0; i <= QTR; i++) begin
      tw_rom[i] = quarter_q15(i);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        write_length(PLAN[i].val[CFG_W-1:0]);
      end else begin
        push_sample(PLAN[i].val, PLAN[i].typed, PLAN[i].re0, PLAN[i].im0);
      end
    end

    rand_sent = 0;
    phase     = 0;
    while (rand_sent < RAND_ITEMS) begin
      case (phase)
        0: begin
          code   = LG_MIN;
          blocks = 6;
        end
        1: begin
          code   = LG_OVER;
          blocks = 1;
        end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            code = CFG_W'($urandom_range(0, 7));
          end else begin
            code = CFG_W'($urandom_range(0, 4));
          end
          blocks = $urandom_range(1, 3);
        end
      endcase
      write_length(code);
      if (phase == 0) begin
        long_hold_req = 1'b1;
      end
      npts = length_now();
      for (b = 0; b < blocks && rand_sent < RAND_ITEMS; b++) begin
        if (b > 0 && $urandom_range(0, 3) == 0) begin
          drain();
        end
        for (j = 0; j < npts && rand_sent < RAND_ITEMS; j++) begin
          push_sample(pick_sample(), 1'b0, '0, '0);
          rand_sent++;
          if (rand_sent >= CALM_AT) begin
            calm = 1'b1;
          end
        end
      end
      phase++;
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d sample transfers, %0d checked bins in %0d blocks",
             smp_cnt, bin_cnt, blk_cnt);
    $display("Lengths used (mask) 0x%0h, length codes written (mask) 0x%0h, one long stall",
             len_mask, code_mask);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
